### design/ssl_pkg.sv
package ssl_pkg;

    // lexer modes
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_BLOCK  = 2'd1,
        MODE_STRING = 2'd2,
        MODE_LINE   = 2'd3
    } mode_t;

    // special bytes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam int MAX_TOKS = 4;
    localparam int Q_DEPTH  = 4;

    // one result
    typedef struct packed {
        logic        ovf;
        logic        last;
        logic [16:0] length;
        logic [15:0] start;
    } tok_t;

    // all results caused by one source byte
    typedef struct packed {
        logic [1:0]            cnt_m1;
        tok_t [MAX_TOKS-1:0]   tok;
    } bundle_t;

    function automatic logic is_single_op(input logic [7:0] c);
        logic r;
        case (c) inside
            "(", ")", "{", "}", ";", ",", ":", ".", "*", "%", "&", "|",
            "^", "~", "<", ">", "!", "=", "+", "-", "/", CH_NL: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_pair_op(input logic [7:0] a, input logic [7:0] b);
        return (a == "<" && (b == "<" || b == "=")) ||
               (a == ">" && (b == ">" || b == "=")) ||
               (a == "=" && b == "=") || (a == "!" && b == "=") ||
               (a == "&" && b == "&") || (a == "|" && b == "|");
    endfunction

endpackage

### design/ssl_front.sv
module ssl_front #(
    parameter int MAX_SOURCE_BYTES = 65536
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             q_full,
    output logic             push,
    output ssl_pkg::bundle_t bundle
);

    localparam int POS_W = $clog2(MAX_SOURCE_BYTES + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_SOURCE_BYTES);
    localparam logic [POS_W-1:0] ONE = POS_W'(1);
    localparam logic [POS_W-1:0] TWO = POS_W'(2);

    logic [7:0]       held_byte_reg, held_byte_next;
    logic             held_valid_reg, held_valid_next;
    ssl_pkg::mode_t   mode_reg, mode_next;
    logic             esc_reg, esc_next;
    logic [POS_W-1:0] base_reg, base_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             ovf_reg, ovf_next;

    logic                            accept;
    logic [2:0]                      tok_cnt;
    ssl_pkg::tok_t [ssl_pkg::MAX_TOKS-1:0] toks;

    function automatic ssl_pkg::tok_t mk_tok(input logic [POS_W-1:0] start,
                                             input logic [POS_W-1:0] len,
                                             input logic last, input logic ovf);
        ssl_pkg::tok_t t;
        logic [31:0]   s32;
        logic [31:0]   l32;
        s32 = 32'(start);
        l32 = 32'(len);
        t.start  = s32[15:0];
        t.length = l32[16:0];
        t.last   = last;
        t.ovf    = ovf;
        return t;
    endfunction

    assign accept   = in_valid && in_ready;
    assign in_ready = !q_full;

    // next state: walk held byte, then the fresh byte
    always_comb begin : lex_next
        logic [7:0]       b;
        logic [7:0]       h;
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] base;
        ssl_pkg::mode_t   mode;
        logic             esc;
        logic             hv;
        logic [7:0]       hb;
        logic             consumed;
        logic             active;
        logic             keep;
        logic [2:0]       n;
        ssl_pkg::tok_t [ssl_pkg::MAX_TOKS-1:0] slot;

        b        = in_byte;
        h        = held_byte_reg;
        pos      = pos_reg;
        p        = pos_reg - ONE;
        base     = base_reg;
        mode     = mode_reg;
        esc      = esc_reg;
        hv       = held_valid_reg;
        hb       = held_byte_reg;
        consumed = 1'b0;
        keep     = 1'b0;
        n        = 3'd0;
        slot     = '0;
        active   = (b == ssl_pkg::CH_NUL) || (pos_reg < MAX_POS);

        if (active && held_valid_reg) begin
            hv = 1'b0;
            if (mode == ssl_pkg::MODE_BLOCK) begin
                if (h == ssl_pkg::CH_STAR && b == ssl_pkg::CH_SLASH) begin
                    mode     = ssl_pkg::MODE_NORMAL;
                    base     = p + TWO;
                    consumed = 1'b1;
                end
            end else if (h == ssl_pkg::CH_SLASH && b == ssl_pkg::CH_STAR) begin
                if (base < p) begin
                    slot[n[1:0]] = mk_tok(base, p - base, 1'b0, ovf_reg);
                    n = n + 3'd1;
                end
                mode     = ssl_pkg::MODE_BLOCK;
                base     = p + TWO;
                consumed = 1'b1;
            end else if (h == ssl_pkg::CH_SLASH && b == ssl_pkg::CH_SLASH) begin
                if (base < p) begin
                    slot[n[1:0]] = mk_tok(base, p - base, 1'b0, ovf_reg);
                    n = n + 3'd1;
                end
                mode = ssl_pkg::MODE_LINE;
                base = p + ONE;
            end else if (h == ssl_pkg::CH_QUOTE) begin
                if (base < p) begin
                    slot[n[1:0]] = mk_tok(base, p - base, 1'b0, ovf_reg);
                    n = n + 3'd1;
                end
                mode = ssl_pkg::MODE_STRING;
                esc  = 1'b0;
                base = p;
            end else if (h == ssl_pkg::CH_SPACE || h == ssl_pkg::CH_TAB ||
                         h == ssl_pkg::CH_CR) begin
                if (base < p) begin
                    slot[n[1:0]] = mk_tok(base, p - base, 1'b0, ovf_reg);
                    n = n + 3'd1;
                end
                base = p + ONE;
            end else if (ssl_pkg::is_pair_op(h, b)) begin
                if (base < p) begin
                    slot[n[1:0]] = mk_tok(base, p - base, 1'b0, ovf_reg);
                    n = n + 3'd1;
                end
                slot[n[1:0]] = mk_tok(p, TWO, 1'b0, ovf_reg);
                n = n + 3'd1;
                base     = p + TWO;
                consumed = 1'b1;
            end else if (ssl_pkg::is_single_op(h)) begin
                if (base < p) begin
                    slot[n[1:0]] = mk_tok(base, p - base, 1'b0, ovf_reg);
                    n = n + 3'd1;
                end
                slot[n[1:0]] = mk_tok(p, ONE, 1'b0, ovf_reg);
                n = n + 3'd1;
                base = p + ONE;
            end
        end

        held_byte_next  = hb;
        held_valid_next = hv;
        mode_next       = mode;
        esc_next        = esc;
        base_next       = base;
        pos_next        = pos;
        ovf_next        = ovf_reg;

        if (b == ssl_pkg::CH_NUL) begin
            // end of source: flush, end marker, back to reset state
            if (base < pos) begin
                slot[n[1:0]] = mk_tok(base, pos - base, 1'b0, ovf_reg);
                n = n + 3'd1;
            end
            slot[n[1:0]] = mk_tok('0, '0, 1'b1, ovf_reg);
            n = n + 3'd1;
            held_byte_next  = '0;
            held_valid_next = 1'b0;
            mode_next       = ssl_pkg::MODE_NORMAL;
            esc_next        = 1'b0;
            base_next       = '0;
            pos_next        = '0;
            ovf_next        = 1'b0;
        end else if (!active) begin
            // past the bound: byte dropped
            ovf_next = 1'b1;
        end else begin
            if (!consumed) begin
                if (mode == ssl_pkg::MODE_STRING) begin
                    if (esc) begin
                        esc = 1'b0;
                    end else if (b == ssl_pkg::CH_BSLASH) begin
                        esc = 1'b1;
                    end else if (b == ssl_pkg::CH_QUOTE) begin
                        if (base < pos + ONE) begin
                            slot[n[1:0]] = mk_tok(base, pos + ONE - base, 1'b0, ovf_reg);
                            n = n + 3'd1;
                        end
                        mode = ssl_pkg::MODE_NORMAL;
                        base = pos + ONE;
                    end
                end else begin
                    keep = 1'b1;
                    if (mode == ssl_pkg::MODE_LINE) begin
                        if (b == ssl_pkg::CH_NL) begin
                            mode = ssl_pkg::MODE_NORMAL;
                            base = pos;
                        end else begin
                            base = pos + ONE;
                            keep = 1'b0;
                        end
                    end
                    if (keep) begin
                        hb = b;
                        hv = 1'b1;
                    end
                end
            end
            held_byte_next  = hb;
            held_valid_next = hv;
            mode_next       = mode;
            esc_next        = esc;
            base_next       = base;
            pos_next        = pos + ONE;
        end

        tok_cnt = n;
        toks    = slot;
    end

    // outputs toward the queue
    always_comb begin : lex_out
        logic [2:0] cm1;
        cm1            = tok_cnt - 3'd1;
        push           = accept && (tok_cnt != 3'd0);
        bundle.tok     = toks;
        bundle.cnt_m1  = cm1[1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            mode_reg       <= ssl_pkg::MODE_NORMAL;
            esc_reg        <= 1'b0;
            base_reg       <= '0;
            pos_reg        <= '0;
            ovf_reg        <= 1'b0;
        end else if (accept) begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            mode_reg       <= mode_next;
            esc_reg        <= esc_next;
            base_reg       <= base_next;
            pos_reg        <= pos_next;
            ovf_reg        <= ovf_next;
        end
    end

    // end of source returns position and lookahead to reset state
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_byte == ssl_pkg::CH_NUL |=> pos_reg == '0 && !held_valid_reg
            && mode_reg == ssl_pkg::MODE_NORMAL)
        else $error("end of source did not clear lexer state");

    // a dropped byte never yields a result
    a_drop_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_byte != ssl_pkg::CH_NUL && pos_reg >= MAX_POS |-> !push)
        else $error("dropped byte produced a result");

endmodule

### design/ssl_queue.sv
module ssl_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ssl_pkg::bundle_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output ssl_pkg::bundle_t head
);

    localparam int PTR_W = $clog2(ssl_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(ssl_pkg::Q_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(ssl_pkg::Q_DEPTH);

    ssl_pkg::bundle_t mem [ssl_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == DEPTH_C);
    assign valid = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> count_reg != DEPTH_C)
        else $error("push into full queue");

endmodule

### design/ssl_back.sv
module ssl_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  ssl_pkg::bundle_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output ssl_pkg::tok_t    out_tok
);

    logic [1:0]    idx_reg, idx_next;
    logic          valid_reg, valid_next;
    ssl_pkg::tok_t tok_reg;
    logic          load_ok;
    logic          take;

    assign load_ok   = !valid_reg || out_ready;
    assign take      = q_valid && load_ok;
    assign pop       = take && (idx_reg == head.cnt_m1);
    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
            idx_next   = pop ? 2'd0 : idx_reg + 2'd1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            tok_reg <= head.tok[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // a partly sent bundle stays at the head and the index stays inside it
    a_idx_in_bundle: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != 2'd0 |-> q_valid && idx_reg <= head.cnt_m1)
        else $error("result index outside current bundle");

endmodule

### design/script_source_lexer.sv
// Source lexer for a C-style script language.
// Input stream (s_*): one source byte per request in s_tdata; byte 0 ends
// the source and resets all lexer state for the next one.
// Output stream (m_*): one token per request, offset and length in m_tdata;
// m_tlast marks the end-of-source terminator, m_tuser flags a source that
// ran past MAX_SOURCE_BYTES (later positions saturate, bytes dropped).
// Throughput: one byte per cycle while the queue is not full. The front
// lexer keeps a one-byte lookahead and resolves each byte combinationally;
// a byte that closes tokens hands them (up to three, at end of source) as
// one bundle to a 4-entry queue. The back end sends one token per cycle
// from the queue head while m_tready is high; the tokens of one bundle
// leave one after another through the single output register.
// A token passes through the queue and then the output register; the byte
// that closes it is at most two bytes after its last byte.
// Reset: synchronous, active-low aresetn; clears lexer state, queue and
// output valid. A stalled m_tready holds the output; the queue absorbs
// bursts, and s_tready drops only when the queue is full.
module script_source_lexer #(
    parameter int MAX_SOURCE_BYTES = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] src_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] token_start, [32:16] token_length, zero fill
    output logic        m_tlast,   // end_marker
    output logic [0:0]  m_tuser    // [0] source_overflow
);

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;
    ssl_pkg::bundle_t q_in;
    ssl_pkg::bundle_t q_head;
    ssl_pkg::tok_t    out_tok;

    // front: lexer state, lookahead, token closing
    ssl_front #(
        .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .q_full   (q_full),
        .push     (q_push),
        .bundle   (q_in)
    );

    // decoupling queue of per-byte token bundles
    ssl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    // back: serialize bundles onto the output stream
    ssl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok)
    );

    assign m_tdata = {7'd0, out_tok.length, out_tok.start};
    assign m_tlast = out_tok.last;
    assign m_tuser = out_tok.ovf;

endmodule

### tb/tb_script_source_lexer.sv
module tb_script_source_lexer;
    timeunit 1ns;
    timeprecision 1ps;

    // offset bound, matches the default of the block
    localparam int unsigned SRC_LIMIT = 65536;
    // cycles with no request on either side before the run is abandoned
    localparam int unsigned STALL_LIMIT = 4000;
    // rough size of the random part, in source bytes
    localparam int RANDOM_BYTES = 460;

    localparam string OP_CHARS   = "(){};,:.*%&|^~<>!=+-/\n";
    localparam string PAIR_CHARS = "<<>><=>===!=&&||";

    // ------------------------------------------------------------------
    // Token predictor and checker. Keeps its own lexer state, turns every
    // accepted source byte into the tokens it closes, and matches tokens
    // leaving the block against them in order.
    // ------------------------------------------------------------------
    class lexer_scoreboard;
        bit [7:0]       held;
        bit             held_ok;
        ssl_pkg::mode_t mode;
        bit             esc;
        int unsigned    base;      // first byte of the pending token
        int unsigned    pos;       // offset of the next source byte
        bit             ovf;
        int             made;      // tokens produced by the current byte
        ssl_pkg::tok_t  want_q[$];
        int             errors;
        int             seen;
        int             sources;
        int             bytes_in;

        function new();
            clear_state();
            errors   = 0;
            seen     = 0;
            sources  = 0;
            bytes_in = 0;
        endfunction

        function void clear_state();
            held    = 8'h00;
            held_ok = 1'b0;
            mode    = ssl_pkg::MODE_NORMAL;
            esc     = 1'b0;
            base    = 0;
            pos     = 0;
            ovf     = 1'b0;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void push_tok(int unsigned start, int unsigned len, bit endm);
            ssl_pkg::tok_t t;
            if (made < ssl_pkg::MAX_TOKS) begin
                t.ovf    = ovf;
                t.last   = endm;
                t.length = len[16:0];
                t.start  = start[15:0];
                want_q.push_back(t);
                made++;
            end
        endfunction

        function void flush(int unsigned p);
            if (base < p) push_tok(base, p - base, 1'b0);
        endfunction

        function bit is_op1(bit [7:0] c);
            for (int i = 0; i < OP_CHARS.len(); i++) begin
                if (OP_CHARS[i] == c) return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit is_op2(bit [7:0] a, bit [7:0] b);
            for (int i = 0; i < PAIR_CHARS.len(); i += 2) begin
                if (PAIR_CHARS[i] == a && PAIR_CHARS[i+1] == b) return 1'b1;
            end
            return 1'b0;
        endfunction

        // held byte at offset p, lookahead b (0 at end); 1 when b is eaten too
        function bit take_held(int unsigned p, bit [7:0] b);
            bit [7:0] h;
            h       = held;
            held_ok = 1'b0;
            if (mode == ssl_pkg::MODE_BLOCK) begin
                if (h == ssl_pkg::CH_STAR && b == ssl_pkg::CH_SLASH) begin
                    mode = ssl_pkg::MODE_NORMAL;
                    base = p + 2;
                    return 1'b1;
                end
                return 1'b0;
            end
            if (h == ssl_pkg::CH_SLASH && b == ssl_pkg::CH_STAR) begin
                flush(p);
                mode = ssl_pkg::MODE_BLOCK;
                base = p + 2;
                return 1'b1;
            end
            if (h == ssl_pkg::CH_SLASH && b == ssl_pkg::CH_SLASH) begin
                flush(p);
                mode = ssl_pkg::MODE_LINE;
                base = p + 1;
                return 1'b0;
            end
            if (h == ssl_pkg::CH_QUOTE) begin
                flush(p);
                mode = ssl_pkg::MODE_STRING;
                esc  = 1'b0;
                base = p;
                return 1'b0;
            end
            if (h == ssl_pkg::CH_SPACE || h == ssl_pkg::CH_TAB || h == ssl_pkg::CH_CR) begin
                flush(p);
                base = p + 1;
                return 1'b0;
            end
            if (b != ssl_pkg::CH_NUL && is_op2(h, b)) begin
                flush(p);
                push_tok(p, 2, 1'b0);
                base = p + 2;
                return 1'b1;
            end
            if (is_op1(h)) begin
                flush(p);
                push_tok(p, 1, 1'b0);
                base = p + 1;
            end
            return 1'b0;
        endfunction

        // fresh byte b at offset q that the held byte left alone
        function void take_fresh(int unsigned q, bit [7:0] b);
            if (mode == ssl_pkg::MODE_STRING) begin
                if (esc) begin
                    esc = 1'b0;
                end else if (b == ssl_pkg::CH_BSLASH) begin
                    esc = 1'b1;
                end else if (b == ssl_pkg::CH_QUOTE) begin
                    flush(q + 1);
                    mode = ssl_pkg::MODE_NORMAL;
                    base = q + 1;
                end
                return;
            end
            if (mode == ssl_pkg::MODE_LINE) begin
                if (b == ssl_pkg::CH_NL) begin
                    mode = ssl_pkg::MODE_NORMAL;
                    base = q;
                end else begin
                    base = q + 1;
                    return;
                end
            end
            held    = b;
            held_ok = 1'b1;
        endfunction

        function void note_byte(bit [7:0] b);
            bit ate;
            made = 0;
            ate  = 1'b0;
            bytes_in++;
            if (b == ssl_pkg::CH_NUL) begin
                if (held_ok) ate = take_held(pos - 1, ssl_pkg::CH_NUL);
                flush(pos);
                push_tok(0, 0, 1'b1);
                sources++;
                clear_state();
                return;
            end
            // past the bound: byte dropped, flag sticks until the end marker
            if (pos >= SRC_LIMIT) begin
                ovf = 1'b1;
                return;
            end
            if (held_ok) ate = take_held(pos - 1, b);
            if (!ate) take_fresh(pos, b);
            pos++;
        endfunction

        function void check_tok(logic [39:0] data, logic last, logic ovf_bit);
            ssl_pkg::tok_t w;
            seen++;
            if (want_q.size() == 0) begin
                $error("unexpected token: start %0d length %0d last %0b overflow %0b",
                       data[15:0], data[32:16], last, ovf_bit);
                errors++;
                return;
            end
            w = want_q.pop_front();
            if (data[15:0] !== w.start) begin
                $error("token_start: expected %0d, got %0d", w.start, data[15:0]);
                errors++;
            end
            if (data[32:16] !== w.length) begin
                $error("token_length: expected %0d, got %0d", w.length, data[32:16]);
                errors++;
            end
            if (last !== w.last) begin
                $error("end_marker: expected %0b, got %0b", w.last, last);
                errors++;
            end
            if (ovf_bit !== w.ovf) begin
                $error("source_overflow: expected %0b, got %0b", w.ovf, ovf_bit);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, block
    // ------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;    // [7:0] src_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;             // [15:0] token_start, [32:16] token_length
    logic        m_tlast;             // end_marker
    logic [0:0]  m_tuser;             // [0] source_overflow

    lexer_scoreboard sb = new();

    bit       calm     = 1'b0;        // no idling on either side while set
    bit       hold_req = 1'b0;        // asks the receiver for a long hold-off
    bit [7:0] stim_q[$];

    script_source_lexer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Source text builders
    // ------------------------------------------------------------------
    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) stim_q.push_back(s[i]);
    endfunction

    // letters, digits and UTF-8 style high bytes
    function automatic bit [7:0] word_byte();
        bit [7:0] c;
        case ($urandom_range(0, 3))
            0, 1:    c = 8'("a" + $urandom_range(0, 25));
            2:       c = 8'("0" + $urandom_range(0, 9));
            default: c = 8'($urandom_range(8'h80, 8'hff));
        endcase
        return c;
    endfunction

    function automatic bit [7:0] any_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    // body text for strings and comments, never a 0
    function automatic void put_body(int n, bit in_string);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: if (in_string) begin
                    stim_q.push_back(ssl_pkg::CH_BSLASH);
                    stim_q.push_back($urandom_range(0, 1) ? ssl_pkg::CH_QUOTE : any_byte());
                end else begin
                    stim_q.push_back(ssl_pkg::CH_STAR);
                end
                1: stim_q.push_back(in_string ? any_byte() : ssl_pkg::CH_SLASH);
                2: stim_q.push_back(ssl_pkg::CH_NL);
                default: stim_q.push_back(word_byte());
            endcase
        end
    endfunction

    // one lexical piece, mostly well formed, some noise and broken sources
    function automatic void put_snippet();
        int       k;
        bit [7:0] ch;
        case ($urandom_range(0, 12))
            0, 1: begin
                repeat ($urandom_range(1, 6)) stim_q.push_back(word_byte());
            end
            2: stim_q.push_back(OP_CHARS[$urandom_range(0, OP_CHARS.len() - 1)]);
            3: begin
                k = 2 * $urandom_range(0, PAIR_CHARS.len() / 2 - 1);
                stim_q.push_back(PAIR_CHARS[k]);
                stim_q.push_back(PAIR_CHARS[k+1]);
            end
            4: begin
                case ($urandom_range(0, 2))
                    0:       stim_q.push_back(ssl_pkg::CH_SPACE);
                    1:       stim_q.push_back(ssl_pkg::CH_TAB);
                    default: stim_q.push_back(ssl_pkg::CH_CR);
                endcase
            end
            5: stim_q.push_back(ssl_pkg::CH_NL);
            6: begin
                stim_q.push_back(ssl_pkg::CH_QUOTE);
                put_body($urandom_range(0, 5), 1'b1);
                stim_q.push_back(ssl_pkg::CH_QUOTE);
            end
            7: begin
                put_text("/*");
                put_body($urandom_range(0, 5), 1'b0);
                put_text("*/");
            end
            8: begin
                put_text("//");
                repeat ($urandom_range(0, 5)) begin
                    ch = any_byte();
                    stim_q.push_back(ch == ssl_pkg::CH_NL ? 8'("c") : ch);
                end
                stim_q.push_back(ssl_pkg::CH_NL);
            end
            9: begin
                repeat ($urandom_range(1, 3)) stim_q.push_back(any_byte());
            end
            10: begin
                // open comment or string running into the end of source
                if ($urandom_range(0, 1)) begin
                    put_text("/*");
                    put_body($urandom_range(0, 4), 1'b0);
                end else begin
                    stim_q.push_back(ssl_pkg::CH_QUOTE);
                    put_body($urandom_range(0, 4), 1'b1);
                    if ($urandom_range(0, 1)) stim_q.push_back(ssl_pkg::CH_BSLASH);
                end
                stim_q.push_back(ssl_pkg::CH_NUL);
            end
            11: stim_q.push_back(ssl_pkg::CH_NUL);
            default: stim_q.push_back(word_byte());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender side: one source byte per request, random gaps.
    // Entered and left just after a falling edge.
    // ------------------------------------------------------------------
    task automatic send_byte(input bit [7:0] b);
        while (!calm && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b);
        @(negedge aclk);
    endtask

    task automatic send_queue();
        for (int i = 0; i < stim_q.size(); i++) send_byte(stim_q[i]);
        stim_q.delete();
    endtask

    // sender goes quiet until every predicted token has left the block
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random back-pressure, plus one long hold-off counted
    // here so the lexer queue fills and s_tready drops.
    // ------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = 120;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 8);
            end
        end
    end

    // token monitor
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_tok(m_tdata, m_tlast, m_tuser[0]);
        end
    end

    // watchdog: gives up after a long run of cycles with no request moving
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: operators, whitespace kinds, a high byte
        put_text("f(x)<=");
        stim_q.push_back(ssl_pkg::CH_TAB);
        stim_q.push_back(ssl_pkg::CH_CR);
        stim_q.push_back(8'hff);
        put_text(";");
        stim_q.push_back(ssl_pkg::CH_NUL);
        // string holding an escaped quote, then a line comment cut by the end
        put_text("\"\\\"\"//c");
        stim_q.push_back(ssl_pkg::CH_NUL);
        // block comment left open
        put_text("/*z");
        stim_q.push_back(ssl_pkg::CH_NUL);
        // string left open, backslash as its last byte
        put_text("\"q\\");
        stim_q.push_back(ssl_pkg::CH_NUL);
        // empty source
        stim_q.push_back(ssl_pkg::CH_NUL);
        send_queue();
        drain();

        // random sources, mostly well formed
        while (stim_q.size() < RANDOM_BYTES) put_snippet();
        stim_q.push_back(ssl_pkg::CH_NUL);
        for (int i = 0; i < stim_q.size(); i++) begin
            if (i == 150) hold_req = 1'b1;
            calm = (i >= 250 && i < 350);
            send_byte(stim_q[i]);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Lexed %0d sources (%0d bytes) into %0d checked tokens,", sb.sources,
                 sb.bytes_in, sb.seen);
        $display("with open comments and strings, escapes, and output stalls.");
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
design/ssl_pkg.sv
design/ssl_front.sv
design/ssl_queue.sv
design/ssl_back.sv
design/script_source_lexer.sv
tb/tb_script_source_lexer.sv
